>>> src/fwdf_pkg.sv
// ----------------------------------------------------------------------------
// fwdf_pkg
// Shared constants and the item record for the fixed width decimal formatter.
// ----------------------------------------------------------------------------
package fwdf_pkg;

    localparam int DEC_DIGITS = 5;

    localparam logic [2:0]  DIGITS_DONE = 3'(DEC_DIGITS);
    localparam logic [3:0]  UNITS_POS   = 4'd0;
    localparam logic [3:0]  TOP_DIG_POS = 4'(DEC_DIGITS);

    localparam logic [7:0]  CH_HASH = 8'h23;
    localparam logic [7:0]  CH_ZERO = 8'h30;

    // x / 10 == (x * RECIP) >> RECIP_SHIFT for every 16-bit x
    localparam logic [16:0] RECIP       = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [DEC_DIGITS-1:0][3:0] digits;
        logic [3:0]                 width;
        logic [7:0]                 fill;
        logic                       over;
    } fwdf_rec_t;

endpackage

>>> src/fwdf_front.sv
// ----------------------------------------------------------------------------
// fwdf_front
// Accepts items, saturates the width, flags overflow and splits the value
// into decimal digits with one divide-by-ten step per cycle.
// ----------------------------------------------------------------------------
module fwdf_front
    import fwdf_pkg::*;
#(
    parameter int MAX_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] in_value,
    input  logic [3:0]  in_width,
    input  logic [7:0]  in_fill,
    output logic        push_valid,
    input  logic        push_ready,
    output fwdf_rec_t   push_rec
);

    logic        busy_reg, busy_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [DEC_DIGITS-1:0][3:0] dig_reg, dig_next;
    logic [3:0]  width_reg, width_next;
    logic [7:0]  fill_reg, fill_next;
    logic        over_reg, over_next;

    logic        done;
    logic        take;
    logic [3:0]  w_sat;
    logic [16:0] lim;
    logic        over_in;
    logic [32:0] prod;
    logic [13:0] quo;
    logic [16:0] quo_x10;
    logic [3:0]  digit;

    function automatic logic [16:0] pow10(input logic [3:0] n);
        logic [16:0] r;
        unique case (n)
            4'd1:    r = 17'd10;
            4'd2:    r = 17'd100;
            4'd3:    r = 17'd1000;
            4'd4:    r = 17'd10000;
            default: r = 17'h1ffff;
        endcase
        return r;
    endfunction

    assign done       = (cnt_reg == DIGITS_DONE);
    assign push_valid = busy_reg && done;
    assign in_ready   = !busy_reg || (done && push_ready);
    assign take       = in_valid && in_ready;

    assign w_sat   = (int'(in_width) > MAX_WIDTH) ? 4'(MAX_WIDTH) : in_width;
    assign lim     = pow10(w_sat);
    assign over_in = ({1'b0, in_value} >= lim);

    assign prod    = {17'd0, rem_reg} * {16'd0, RECIP};
    assign quo     = prod[RECIP_SHIFT +: 14];
    assign quo_x10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
    assign digit   = 4'(({1'b0, rem_reg}) - quo_x10);

    assign push_rec.digits = dig_reg;
    assign push_rec.width  = width_reg;
    assign push_rec.fill   = fill_reg;
    assign push_rec.over   = over_reg;

    always_comb begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dig_next   = dig_reg;
        width_next = width_reg;
        fill_next  = fill_reg;
        over_next  = over_reg;
        if (busy_reg && !done) begin
            rem_next = {2'b00, quo};
            dig_next = {digit, dig_reg[DEC_DIGITS-1:1]};
            cnt_next = cnt_reg + 3'd1;
        end
        if (busy_reg && done && push_ready) begin
            busy_next = 1'b0;
        end
        if (take && (w_sat != 4'd0)) begin
            busy_next  = 1'b1;
            cnt_next   = 3'd0;
            rem_next   = in_value;
            width_next = w_sat;
            fill_next  = in_fill;
            over_next  = over_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg   <= rem_next;
        dig_reg   <= dig_next;
        width_reg <= width_next;
        fill_reg  <= fill_next;
        over_reg  <= over_next;
    end

endmodule

>>> src/fwdf_queue.sv
// ----------------------------------------------------------------------------
// fwdf_queue
// Two-entry queue of digit records between the front and back parts.
// ----------------------------------------------------------------------------
module fwdf_queue
    import fwdf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  fwdf_rec_t push_rec,
    output logic      head_valid,
    input  logic      pop,
    output fwdf_rec_t head_rec
);

    fwdf_rec_t   mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

>>> src/fwdf_back.sv
// ----------------------------------------------------------------------------
// fwdf_back
// Walks the field from the most significant position down and emits one
// character per beat into the output register.
// ----------------------------------------------------------------------------
module fwdf_back
    import fwdf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      head_valid,
    input  fwdf_rec_t head_rec,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [7:0] out_char,
    output logic      out_last
);

    logic       first_reg, first_next;
    logic [3:0] pos_reg, pos_next;
    logic       seen_reg, seen_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;

    logic       load;
    logic [3:0] p;
    logic [3:0] d;
    logic [7:0] ch;

    assign load = head_valid && (!valid_reg || out_ready);
    assign p    = first_reg ? (head_rec.width - 4'd1) : pos_reg;
    assign pop  = load && (p == UNITS_POS);

    always_comb begin
        unique case (p)
            4'd0:    d = head_rec.digits[0];
            4'd1:    d = head_rec.digits[1];
            4'd2:    d = head_rec.digits[2];
            4'd3:    d = head_rec.digits[3];
            4'd4:    d = head_rec.digits[4];
            default: d = 4'd0;
        endcase
    end

    always_comb begin
        priority if (head_rec.over) begin
            ch = CH_HASH;
        end else if (p >= TOP_DIG_POS) begin
            ch = head_rec.fill;
        end else if ((p == UNITS_POS) || seen_reg || (d != 4'd0)) begin
            ch = CH_ZERO + {4'd0, d};
        end else begin
            ch = head_rec.fill;
        end
    end

    always_comb begin
        first_next = first_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            char_next  = ch;
            last_next  = (p == UNITS_POS);
            if (p == UNITS_POS) begin
                first_next = 1'b1;
                seen_next  = 1'b0;
            end else begin
                first_next = 1'b0;
                pos_next   = p - 4'd1;
                seen_next  = seen_reg || ((p < TOP_DIG_POS) && (d != 4'd0));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            seen_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            first_reg <= first_next;
            seen_reg  <= seen_next;
            valid_reg <= valid_next;
        end
        pos_reg  <= pos_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

>>> src/fixed_width_decimal_formatter_top.sv
// ----------------------------------------------------------------------------
// fixed_width_decimal_formatter_top
// Formats a 16-bit unsigned value as a right-aligned decimal ASCII field.
// ----------------------------------------------------------------------------
// Each input beat carries a value, a width and a fill character; the block
// sends exactly width characters, most significant first, tlast on the final
// one (width is capped at MAX_WIDTH, a zero width produces nothing). Leading
// positions and leading zeros show the fill character, the units digit always
// prints, and a value too long for the field gives all '#'. The front part
// needs five passes through one divide-by-ten unit per item plus the hand-off,
// and the back part sends one character per cycle while the output does not
// stall; a two-entry queue lets the front convert the next item while the back
// still sends.
module fixed_width_decimal_formatter_top
    import fwdf_pkg::*;
#(
    parameter int MAX_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[15:0], width[19:16], fill_char[27:20], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char[7:0]
    output logic        m_tlast
);

    logic      push_valid;
    logic      push_ready;
    fwdf_rec_t push_rec;
    logic      head_valid;
    fwdf_rec_t head_rec;
    logic      pop;

    fwdf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_value   (s_tdata[15:0]),
        .in_width   (s_tdata[19:16]),
        .in_fill    (s_tdata[27:20]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    fwdf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .head_valid (head_valid),
        .pop        (pop),
        .head_rec   (head_rec)
    );

    fwdf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

>>> bench/fixed_width_decimal_formatter_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_width_decimal_formatter_top_test
// Self-checking bench for the fixed width decimal formatter.
// ----------------------------------------------------------------------------
// A short table of hand-picked beats comes first: extreme values, zero and
// oversized widths, overflow to '#', and odd fill characters. Rows whose
// text is obvious carry it typed in; the rest are checked against a local
// model. About a hundred random beats follow, with most values drawn by digit
// count so that fill, zeros and overflow all occur. Both sides stall at random
// and some stretches run flat out. Every output beat is matched in order
// against the queue of expected characters.
// ----------------------------------------------------------------------------
module fixed_width_decimal_formatter_top_test;
    import fwdf_pkg::*;

    localparam int MAX_WIDTH   = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 24;
    localparam int RANDOM_BEATS = 106;

    typedef struct {
        logic [15:0] value;
        logic [3:0]  width;
        logic [7:0]  fill;
        bit          typed;
        string       text;
    } field_row_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    char_beat_t  pending_chars[$];
    char_beat_t  got_char;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    int          ready_roll;
    bit          calm = 1'b0;

    field_row_t field_rows[] = '{
        '{16'd0,     4'd1,  8'h2a, 1'b1, "0"},
        '{16'd65535, 4'd5,  8'h20, 1'b1, "65535"},
        '{16'd65535, 4'd8,  8'h2e, 1'b1, "...65535"},
        '{16'd65535, 4'd4,  8'h20, 1'b1, "####"},
        '{16'd10,    4'd1,  8'h20, 1'b1, "#"},
        '{16'd0,     4'd0,  8'h20, 1'b1, ""},
        '{16'd12345, 4'd15, 8'h2d, 1'b1, "---12345"},
        '{16'd9,     4'd1,  8'h20, 1'b1, "9"},
        '{16'd10000, 4'd5,  8'h20, 1'b1, "10000"},
        '{16'd9999,  4'd4,  8'h20, 1'b1, "9999"},
        '{16'd100,   4'd2,  8'h20, 1'b1, "##"},
        '{16'd99,    4'd3,  8'h20, 1'b1, " 99"},
        '{16'd65535, 4'd3,  8'h20, 1'b1, "###"},
        '{16'd0,     4'd8,  8'h00, 1'b0, ""},
        '{16'd7,     4'd9,  8'hff, 1'b0, ""},
        '{16'd1005,  4'd6,  8'h30, 1'b0, ""},
        '{16'd0,     4'd5,  8'hff, 1'b0, ""},
        '{16'd54321, 4'd10, 8'haa, 1'b0, ""},
        '{16'd1,     4'd12, 8'h55, 1'b0, ""},
        '{16'd0,     4'd0,  8'hff, 1'b0, ""},
        '{16'd32768, 4'd14, 8'h7f, 1'b0, ""},
        '{16'd1,     4'd13, 8'h80, 1'b0, ""},
        '{16'd40960, 4'd11, 8'h01, 1'b0, ""},
        '{16'd305,   4'd7,  8'hfe, 1'b0, ""}
    };

    fixed_width_decimal_formatter_top #(
        .MAX_WIDTH(MAX_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    // right-aligned decimal field with fill, zero blanking and overflow
    function automatic void format_field(input logic [15:0] value, input logic [3:0] width,
                                         input logic [7:0] fill);
        int         field_len;
        int         num_digits;
        int         rest;
        int         pos;
        int         digit_at[DEC_DIGITS];
        char_beat_t beat;
        field_len  = (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);
        rest       = int'(value);
        num_digits = 1;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            digit_at[i] = rest % 10;
            rest        = rest / 10;
            if (digit_at[i] != 0) begin
                num_digits = i + 1;
            end
        end
        for (int k = 0; k < field_len; k++) begin
            pos = field_len - 1 - k;
            if (field_len < num_digits) begin
                beat.ch = CH_HASH;
            end else if (pos >= num_digits) begin
                beat.ch = fill;
            end else begin
                beat.ch = CH_ZERO + 8'(digit_at[pos]);
            end
            beat.last = (k == field_len - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    // present one beat and hold it until the block takes it
    task automatic send_beat(input logic [15:0] value, input logic [3:0] width,
                             input logic [7:0] fill);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, fill, width, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic expect_text(input string text);
        char_beat_t beat;
        for (int i = 0; i < text.len(); i++) begin
            beat.ch   = text[i];
            beat.last = (i == text.len() - 1);
            pending_chars.push_back(beat);
        end
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn || calm) begin
            m_tready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 60) begin
                m_tready <= 1'b1;
            end else if (ready_roll < 93) begin
                hold_left <= $urandom_range(0, 2);
                m_tready  <= 1'b0;
            end else begin
                hold_left <= $urandom_range(8, 30);
                m_tready  <= 1'b0;
            end
        end
    end

    // output checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected beat: out_char %h last %b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                got_char = pending_chars.pop_front();
                if (m_tdata !== got_char.ch) begin
                    $error("out_char: expected %h, got %h", got_char.ch, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== got_char.last) begin
                    $error("last: expected %b, got %b", got_char.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int          digits;
        int          lo;
        int          hi;
        int          roll;
        logic [15:0] value;
        logic [3:0]  width;
        logic [7:0]  fill;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (field_rows[i]) begin
            send_beat(field_rows[i].value, field_rows[i].width, field_rows[i].fill);
            if (field_rows[i].typed) begin
                expect_text(field_rows[i].text);
            end else begin
                format_field(field_rows[i].value, field_rows[i].width, field_rows[i].fill);
            end
        end

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 20 == 0) begin
                calm <= ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                value = 16'($urandom_range(0, 65535));
            end else begin
                digits = $urandom_range(1, DEC_DIGITS);
                lo     = (digits == 1) ? 0 : 10 ** (digits - 1);
                hi     = (digits == DEC_DIGITS) ? 65535 : 10 ** digits - 1;
                value  = 16'($urandom_range(lo, hi));
            end
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                width = 4'd0;
            end else if (roll < 15) begin
                width = 4'($urandom_range(MAX_WIDTH + 1, 15));
            end else begin
                width = 4'($urandom_range(1, MAX_WIDTH));
            end
            fill = 8'($urandom_range(0, 255));
            send_beat(value, width, fill);
            format_field(value, width, fill);
        end

        s_tvalid <= 1'b0;
        calm     <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
src/fwdf_pkg.sv
src/fwdf_front.sv
src/fwdf_queue.sv
src/fwdf_back.sv
src/fixed_width_decimal_formatter_top.sv
bench/fixed_width_decimal_formatter_top_test.sv
